// ===== src/tsts_pkg.sv =====
// ----------------------------------------------------------------------------
// tsts_pkg
// Shared types, codes and defaults of the time-slice task scheduler.
// ----------------------------------------------------------------------------
package tsts_pkg;

	localparam int DEF_TASK_SLOTS = 16;
	localparam int DEF_TIME_BITS  = 32;
	localparam int IQ_DEPTH       = 2;
	localparam int OQ_DEPTH       = 4;

	localparam logic [31:0] DEFAULT_PERIOD  = 32'd5000;
	localparam logic [31:0] DEF_LOW_RUN     = 32'd2000;
	localparam logic [4:0]  DEF_MAX_CONC    = 5'd4;

	// request codes on the input
	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_ADD      = 3'd1;
	localparam logic [2:0] REQ_COMPLETE = 3'd2;
	localparam logic [2:0] REQ_RESTART  = 3'd3;
	localparam logic [2:0] REQ_SETPRIO  = 3'd4;
	localparam logic [2:0] REQ_CLEAR    = 3'd5;
	localparam logic [2:0] REQ_SPARE6   = 3'd6;
	localparam logic [2:0] REQ_SPARE7   = 3'd7;

	// classified operations handed to the back end
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_ADD      = 3'd1;
	localparam logic [2:0] OP_COMPLETE = 3'd2;
	localparam logic [2:0] OP_RESTART  = 3'd3;
	localparam logic [2:0] OP_SETPRIO  = 3'd4;
	localparam logic [2:0] OP_CLEAR    = 3'd5;
	localparam logic [2:0] OP_NOP      = 3'd6;

	// result events
	localparam logic [2:0] EV_DONE      = 3'd0;
	localparam logic [2:0] EV_REMOVED   = 3'd1;
	localparam logic [2:0] EV_SUSPENDED = 3'd2;
	localparam logic [2:0] EV_STARTED   = 3'd3;
	localparam logic [2:0] EV_ALLOC     = 3'd4;
	localparam logic [2:0] EV_FULL      = 3'd5;
	localparam logic [2:0] EV_INVALID   = 3'd6;

	// configuration register indexes
	localparam logic [2:0] CFG_LOW_RUN   = 3'd0;
	localparam logic [2:0] CFG_HIGH_RUN  = 3'd1;
	localparam logic [2:0] CFG_SUSPEND   = 3'd2;
	localparam logic [2:0] CFG_MAX_CONC  = 3'd3;
	localparam logic [2:0] CFG_STAGGER   = 3'd4;
	localparam logic [2:0] CFG_ENABLE    = 3'd5;

	typedef struct packed {
		logic [31:0] low_run_time;
		logic [31:0] high_run_time;
		logic [31:0] susp_period;
		logic [4:0]  max_concurrent;
		logic [31:0] stagger_window;
		logic        scheduler_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  task_slot;
		logic        task_priority;
		logic        auto_remove;
		logic [31:0] now_ms;
		logic [31:0] stagger_value;
	} op_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [3:0] slot_id;
		logic [4:0] running_count;
		logic [4:0] waiting_count;
		logic       last;
	} res_t;

endpackage

// ===== src/tsts_front.sv =====
// ----------------------------------------------------------------------------
// tsts_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module tsts_front import tsts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic [3:0]  task_slot,
	input  logic        task_priority,
	input  logic        auto_remove,
	input  logic [31:0] now_ms,
	input  logic [31:0] stagger_value,
	output logic        op_avail,
	input  logic        op_pop,
	output op_t         op
);

	localparam int PW = $clog2(IQ_DEPTH);
	localparam int CW = $clog2(IQ_DEPTH + 1);

	op_t           mem_q [IQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;
	op_t           cls;

	always_comb begin
		cls.task_slot     = task_slot;
		cls.task_priority = task_priority;
		cls.auto_remove   = auto_remove;
		cls.now_ms        = now_ms;
		cls.stagger_value = stagger_value;
		case (req_type)
			REQ_TICK:     cls.kind = OP_TICK;
			REQ_ADD:      cls.kind = OP_ADD;
			REQ_COMPLETE: cls.kind = OP_COMPLETE;
			REQ_RESTART:  cls.kind = OP_RESTART;
			REQ_SETPRIO:  cls.kind = OP_SETPRIO;
			REQ_CLEAR:    cls.kind = OP_CLEAR;
			default:      cls.kind = OP_NOP;
		endcase
	end

	assign full     = (cnt_q == CW'(IQ_DEPTH));
	assign op_avail = (cnt_q != '0);
	assign op       = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = op_pop && op_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// ===== src/tsts_outq.sv =====
// ----------------------------------------------------------------------------
// tsts_outq
// Result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module tsts_outq import tsts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic full,
	input  logic pop,
	output logic empty,
	output res_t dout
);

	localparam int PW = $clog2(OQ_DEPTH);
	localparam int CW = $clog2(OQ_DEPTH + 1);

	res_t          mem_q [OQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(OQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== src/tsts_back.sv =====
// ----------------------------------------------------------------------------
// tsts_back
// Slot table and sequencer: sweeps the time store, applies requests and
// walks the slots for suspension and start selection on a tick.
// ----------------------------------------------------------------------------
module tsts_back import tsts_pkg::*; #(
	parameter int TASK_SLOTS = DEF_TASK_SLOTS,
	parameter int TIME_BITS  = DEF_TIME_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic op_avail,
	input  op_t  op_in,
	output logic op_pop,
	input  logic oq_full,
	output logic res_push,
	output res_t res
);

	localparam int N    = TASK_SLOTS;
	localparam int TW   = TIME_BITS;
	localparam int SW   = $clog2(N);
	localparam int CW   = $clog2(N + 1);
	localparam int CMPW = (TW > 32) ? TW : 32;
	localparam logic [SW-1:0] LAST = SW'(N - 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SWEEP  = 4'd1;
	localparam logic [3:0] S_DISP   = 4'd2;
	localparam logic [3:0] S_SUSP   = 4'd3;
	localparam logic [3:0] S_PCHK   = 4'd4;
	localparam logic [3:0] S_PICK   = 4'd5;
	localparam logic [3:0] S_PSTART = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;
	localparam logic [3:0] S_EMIT   = 4'd8;

	typedef struct packed {
		logic [2:0] ev;
		logic [3:0] slot;
		logic       last;
		logic [3:0] ret;
	} emit_t;

	function automatic logic elapsed(input logic [TW-1:0] nw, input logic [TW-1:0] t,
		input logic [31:0] per);
		logic [TW-1:0] diff;
		diff = nw - t;
		return CMPW'(diff) >= CMPW'(per);
	endfunction

	function automatic logic wait_bit(input logic v, input logic r, input logic c,
		input logic e);
		return v & ~r & ~c & e;
	endfunction

	function automatic logic [SW:0] first_set(input logic [N-1:0] v);
		logic [SW:0] r;
		r = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, SW'(i)};
			end
		end
		return r;
	endfunction

	logic [3:0]    state_q, state_d;
	op_t           op_q, op_d;
	logic [N-1:0]  valid_q, valid_d, run_q, run_d, comp_q, comp_d;
	logic [N-1:0]  prio_q, prio_d, arm_q, arm_d, pend_q, pend_d, el_q, el_d;
	logic [CW-1:0] run_cnt_q, run_cnt_d, wait_cnt_q, wait_cnt_d;
	logic [TW-1:0] last_created_q, last_created_d;
	logic [SW-1:0] idx_q, idx_d, pick_q, pick_d;
	logic          found_q, found_d;
	logic [TW-1:0] best_q, best_d;
	emit_t         pend_ev_q, pend_ev_d;

	// time store
	logic [TW-1:0] rs_mem [N];
	logic [TW-1:0] st_mem [N];
	logic [TW-1:0] rs_rd_q, st_rd_q;
	logic          mem_we;
	logic [SW-1:0] mem_wa;
	logic [TW-1:0] rs_wd, st_wd;

	logic [TW-1:0] nowt, new_st;
	logic [31:0]   per, per_m1, stag;
	logic          win_hit, in_rng, ok, e_q_new, e_susp, susp_hit;
	logic [SW-1:0] s_idx;
	logic [SW:0]   rem_enc, free_enc;
	logic [31:0]   limit;

	assign nowt    = TW'(op_q.now_ms);
	assign per     = cfg.susp_period;
	assign per_m1  = per - 32'd1;
	assign win_hit = CMPW'(TW'(nowt - last_created_q)) < CMPW'(cfg.stagger_window);
	assign stag    = (win_hit && per != '0) ?
		((op_q.stagger_value < per_m1) ? op_q.stagger_value : per_m1) : '0;
	assign new_st  = nowt - TW'(per) + TW'(stag);
	assign e_q_new = elapsed(nowt, new_st, per);
	assign e_susp  = (per == '0);
	assign in_rng  = (int'(op_q.task_slot) < N);
	assign s_idx   = in_rng ? SW'(op_q.task_slot) : '0;
	assign ok      = in_rng && valid_q[s_idx];
	assign rem_enc = first_set(valid_q & pend_q);
	assign free_enc = first_set(~valid_q);
	assign limit   = prio_q[idx_q] ? cfg.high_run_time : cfg.low_run_time;
	assign susp_hit = valid_q[idx_q] && run_q[idx_q] &&
		(comp_q[idx_q] || CMPW'(TW'(nowt - rs_rd_q)) >= CMPW'(limit));

	assign res.event_res     = pend_ev_q.ev;
	assign res.slot_id       = pend_ev_q.slot;
	assign res.running_count = 5'(run_cnt_q);
	assign res.waiting_count = 5'(wait_cnt_q);
	assign res.last          = pend_ev_q.last;

	always_comb begin
		state_d        = state_q;
		op_d           = op_q;
		valid_d        = valid_q;
		run_d          = run_q;
		comp_d         = comp_q;
		prio_d         = prio_q;
		arm_d          = arm_q;
		pend_d         = pend_q;
		el_d           = el_q;
		run_cnt_d      = run_cnt_q;
		wait_cnt_d     = wait_cnt_q;
		last_created_d = last_created_q;
		idx_d          = idx_q;
		pick_d         = pick_q;
		found_d        = found_q;
		best_d         = best_q;
		pend_ev_d      = pend_ev_q;
		mem_we         = 1'b0;
		mem_wa         = idx_q;
		rs_wd          = '0;
		st_wd          = '0;
		op_pop         = 1'b0;
		res_push       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (op_avail) begin
					op_pop     = 1'b1;
					op_d       = op_in;
					idx_d      = '0;
					wait_cnt_d = '0;
					state_d    = S_SWEEP;
				end
			end
			S_SWEEP: begin
				// refresh the elapsed flag of each slot and count waiting ones
				el_d[idx_q] = elapsed(nowt, st_rd_q, per);
				wait_cnt_d  = wait_cnt_q + CW'(wait_bit(valid_q[idx_q], run_q[idx_q],
					comp_q[idx_q], el_d[idx_q]));
				if (idx_q == LAST) begin
					idx_d   = '0;
					state_d = S_DISP;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_DISP: begin
				case (op_q.kind)
					OP_TICK: begin
						idx_d = '0;
						if (!cfg.scheduler_enable) begin
							pend_ev_d = '{EV_DONE, 4'd0, 1'b1, S_IDLE};
							state_d   = S_EMIT;
						end else if (rem_enc[SW]) begin
							valid_d[rem_enc[SW-1:0]] = 1'b0;
							run_d[rem_enc[SW-1:0]]   = 1'b0;
							comp_d[rem_enc[SW-1:0]]  = 1'b0;
							pend_d[rem_enc[SW-1:0]]  = 1'b0;
							run_cnt_d  = run_cnt_q - CW'(run_q[rem_enc[SW-1:0]]);
							wait_cnt_d = wait_cnt_q - CW'(wait_bit(1'b1,
								run_q[rem_enc[SW-1:0]], comp_q[rem_enc[SW-1:0]],
								el_q[rem_enc[SW-1:0]]));
							pend_ev_d = '{EV_REMOVED, 4'(rem_enc[SW-1:0]), 1'b0, S_SUSP};
							state_d   = S_EMIT;
						end else begin
							state_d = S_SUSP;
						end
					end
					OP_ADD: begin
						if (!free_enc[SW]) begin
							pend_ev_d = '{EV_FULL, 4'd0, 1'b1, S_IDLE};
						end else begin
							valid_d[free_enc[SW-1:0]] = 1'b1;
							run_d[free_enc[SW-1:0]]   = 1'b0;
							comp_d[free_enc[SW-1:0]]  = 1'b0;
							prio_d[free_enc[SW-1:0]]  = op_q.task_priority;
							arm_d[free_enc[SW-1:0]]   = op_q.auto_remove;
							pend_d[free_enc[SW-1:0]]  = 1'b0;
							el_d[free_enc[SW-1:0]]    = e_q_new;
							mem_we         = 1'b1;
							mem_wa         = free_enc[SW-1:0];
							st_wd          = new_st;
							wait_cnt_d     = wait_cnt_q + CW'(e_q_new);
							last_created_d = nowt;
							pend_ev_d = '{EV_ALLOC, 4'(free_enc[SW-1:0]), 1'b1, S_IDLE};
						end
						state_d = S_EMIT;
					end
					OP_COMPLETE: begin
						if (!ok) begin
							pend_ev_d = '{EV_INVALID, op_q.task_slot, 1'b1, S_IDLE};
						end else begin
							comp_d[s_idx] = 1'b1;
							if (arm_q[s_idx]) begin
								pend_d[s_idx] = 1'b1;
							end
							wait_cnt_d = wait_cnt_q - CW'(wait_bit(1'b1, run_q[s_idx],
								comp_q[s_idx], el_q[s_idx]));
							pend_ev_d = '{EV_DONE, op_q.task_slot, 1'b1, S_IDLE};
						end
						state_d = S_EMIT;
					end
					OP_RESTART: begin
						if (!ok) begin
							pend_ev_d = '{EV_INVALID, op_q.task_slot, 1'b1, S_IDLE};
						end else begin
							comp_d[s_idx] = 1'b0;
							pend_d[s_idx] = 1'b0;
							run_d[s_idx]  = 1'b0;
							el_d[s_idx]   = e_q_new;
							run_cnt_d     = run_cnt_q - CW'(run_q[s_idx]);
							wait_cnt_d    = wait_cnt_q + CW'(e_q_new) - CW'(wait_bit(1'b1,
								run_q[s_idx], comp_q[s_idx], el_q[s_idx]));
							mem_we = 1'b1;
							mem_wa = s_idx;
							st_wd  = new_st;
							pend_ev_d = '{EV_DONE, op_q.task_slot, 1'b1, S_IDLE};
						end
						state_d = S_EMIT;
					end
					OP_SETPRIO: begin
						if (!ok) begin
							pend_ev_d = '{EV_INVALID, op_q.task_slot, 1'b1, S_IDLE};
						end else begin
							prio_d[s_idx] = op_q.task_priority;
							pend_ev_d = '{EV_DONE, op_q.task_slot, 1'b1, S_IDLE};
						end
						state_d = S_EMIT;
					end
					OP_CLEAR: begin
						valid_d        = '0;
						run_d          = '0;
						comp_d         = '0;
						prio_d         = '0;
						arm_d          = '0;
						pend_d         = '0;
						run_cnt_d      = '0;
						wait_cnt_d     = '0;
						last_created_d = '0;
						pend_ev_d = '{EV_DONE, 4'd0, 1'b1, S_IDLE};
						state_d   = S_EMIT;
					end
					default: begin
						pend_ev_d = '{EV_DONE, 4'd0, 1'b1, S_IDLE};
						state_d   = S_EMIT;
					end
				endcase
			end
			S_SUSP: begin
				idx_d = (idx_q == LAST) ? '0 : idx_q + 1'b1;
				if (susp_hit) begin
					run_d[idx_q] = 1'b0;
					el_d[idx_q]  = e_susp;
					run_cnt_d    = run_cnt_q - 1'b1;
					wait_cnt_d   = wait_cnt_q + CW'(~comp_q[idx_q] & e_susp);
					mem_we = 1'b1;
					mem_wa = idx_q;
					st_wd  = nowt;
					pend_ev_d = '{EV_SUSPENDED, 4'(idx_q), 1'b0,
						(idx_q == LAST) ? S_PCHK : S_SUSP};
					state_d = S_EMIT;
				end else if (idx_q == LAST) begin
					state_d = S_PCHK;
				end
			end
			S_PCHK: begin
				found_d = 1'b0;
				if (32'(run_cnt_q) < 32'(cfg.max_concurrent)) begin
					state_d = S_PICK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_PICK: begin
				// latest suspend time wins, lowest slot on a tie
				if (wait_bit(valid_q[idx_q], run_q[idx_q], comp_q[idx_q], el_q[idx_q]) &&
					(!found_q || st_rd_q > best_q)) begin
					found_d = 1'b1;
					pick_d  = idx_q;
					best_d  = st_rd_q;
				end
				if (idx_q == LAST) begin
					state_d = S_PSTART;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_PSTART: begin
				if (found_q) begin
					run_d[pick_q] = 1'b1;
					run_cnt_d     = run_cnt_q + 1'b1;
					wait_cnt_d    = wait_cnt_q - 1'b1;
					mem_we = 1'b1;
					mem_wa = pick_q;
					rs_wd  = nowt;
					pend_ev_d = '{EV_STARTED, 4'(pick_q), 1'b0, S_FIN};
					state_d   = S_EMIT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				pend_ev_d = '{EV_DONE, 4'd0, 1'b1, S_IDLE};
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (!oq_full) begin
					res_push = 1'b1;
					state_d  = pend_ev_q.ret;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			valid_q        <= '0;
			run_q          <= '0;
			comp_q         <= '0;
			prio_q         <= '0;
			arm_q          <= '0;
			pend_q         <= '0;
			run_cnt_q      <= '0;
			wait_cnt_q     <= '0;
			last_created_q <= '0;
			idx_q          <= '0;
			found_q        <= 1'b0;
		end else begin
			state_q        <= state_d;
			valid_q        <= valid_d;
			run_q          <= run_d;
			comp_q         <= comp_d;
			prio_q         <= prio_d;
			arm_q          <= arm_d;
			pend_q         <= pend_d;
			run_cnt_q      <= run_cnt_d;
			wait_cnt_q     <= wait_cnt_d;
			last_created_q <= last_created_d;
			idx_q          <= idx_d;
			found_q        <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		el_q      <= el_d;
		pick_q    <= pick_d;
		best_q    <= best_d;
		pend_ev_q <= pend_ev_d;
	end

	// read address follows the next walk index so data lines up with idx_q
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rs_mem[mem_wa] <= rs_wd;
			st_mem[mem_wa] <= st_wd;
		end
		rs_rd_q <= rs_mem[idx_d];
		st_rd_q <= st_mem[idx_d];
	end

endmodule

// ===== src/time_slice_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// time_slice_task_scheduler_top
// Time-slice task scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Requests are taken into a two-entry queue and executed one at a time. Every
// request first sweeps the slot time store, one slot per cycle, then is applied
// and emits its results, stalling while the result queue is full. A tick adds
// two more walks over the store for suspension and for start selection, one
// slot per cycle except while a suspension result waits to be emitted; a tick
// that finds the running limit reached skips the start walk, and a tick with
// the scheduler off skips both walks like the other requests. Results pass
// through a four-entry queue, so the block keeps working while results wait,
// until that queue fills.
// ----------------------------------------------------------------------------
module time_slice_task_scheduler_top import tsts_pkg::*; #(
	parameter int TASK_SLOTS = DEF_TASK_SLOTS,
	parameter int TIME_BITS  = DEF_TIME_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic [3:0]  task_slot,
	input  logic        task_priority,
	input  logic        auto_remove,
	input  logic [31:0] now_ms,
	input  logic [31:0] stagger_value,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_res,
	output logic [3:0]  slot_id,
	output logic [4:0]  running_count,
	output logic [4:0]  waiting_count,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	op_t  op;
	logic op_avail, op_pop, oq_full, res_push;
	res_t res, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_run_time     <= DEF_LOW_RUN;
			cfg_q.high_run_time    <= DEFAULT_PERIOD;
			cfg_q.susp_period      <= DEFAULT_PERIOD;
			cfg_q.max_concurrent   <= DEF_MAX_CONC;
			cfg_q.stagger_window   <= DEFAULT_PERIOD;
			cfg_q.scheduler_enable <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOW_RUN:  cfg_q.low_run_time     <= cfg_data;
				CFG_HIGH_RUN: cfg_q.high_run_time    <= cfg_data;
				CFG_SUSPEND:  cfg_q.susp_period      <= cfg_data;
				CFG_MAX_CONC: cfg_q.max_concurrent   <= cfg_data[4:0];
				CFG_STAGGER:  cfg_q.stagger_window   <= cfg_data;
				CFG_ENABLE:   cfg_q.scheduler_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tsts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.task_slot    (task_slot),
		.task_priority(task_priority),
		.auto_remove  (auto_remove),
		.now_ms       (now_ms),
		.stagger_value(stagger_value),
		.op_avail     (op_avail),
		.op_pop       (op_pop),
		.op           (op)
	);

	tsts_back #(
		.TASK_SLOTS(TASK_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.op_avail(op_avail),
		.op_in   (op),
		.op_pop  (op_pop),
		.oq_full (oq_full),
		.res_push(res_push),
		.res     (res)
	);

	tsts_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (oq_full),
		.pop   (pop),
		.empty (empty),
		.dout  (head)
	);

	assign event_res     = head.event_res;
	assign slot_id       = head.slot_id;
	assign running_count = head.running_count;
	assign waiting_count = head.waiting_count;
	assign last          = head.last;

endmodule

// ===== src/tsts_checker.sv =====
// ----------------------------------------------------------------------------
// tsts_checker
// Port-level checks on the result stream of the scheduler.
// ----------------------------------------------------------------------------
module tsts_checker import tsts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  event_res,
	input logic [3:0]  slot_id,
	input logic        last
);

	// a waiting result stays until transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before transfer");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(event_res) && $stable(slot_id) && $stable(last)))
		else $error("waiting result changed");

	// tick events are never marked last, since the closing done follows them
	a_tick_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (event_res == EV_REMOVED || event_res == EV_SUSPENDED ||
		event_res == EV_STARTED)) |-> !last)
		else $error("tick event marked last");

	// single-result requests close at once
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (event_res == EV_ALLOC || event_res == EV_FULL ||
		event_res == EV_INVALID)) |-> last)
		else $error("single result not marked last");

endmodule

bind time_slice_task_scheduler_top tsts_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.event_res(event_res),
	.slot_id  (slot_id),
	.last     (last)
);
